### sv/dfa_pkg.sv
package dfa_pkg;

   // Default automaton size.
   localparam int STATE_BITS_DEF  = 6;
   localparam int SYMBOL_BITS_DEF = 8;

   // Fixed widths of the request and response fields.
   localparam int MODE_W   = 3;
   localparam int STATE_W  = 6;
   localparam int SYMBOL_W = 8;

   // Request mode codes.
   localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FINAL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SYMBOL = 3'd3;
   localparam logic [MODE_W-1:0] MODE_END    = 3'd4;

   // Decoded operation carried from the front end to the back end.
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_FINAL,
      OP_START,
      OP_SYMBOL,
      OP_END
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [STATE_W-1:0]    state_id;
      logic [SYMBOL_W-1:0]   symbol;
      logic [STATE_W-1:0]    next_state;
      logic                  final_flag;
   } cmd_type;

   // Back end state machine, one-hot.
   typedef enum logic [2:0] {
      BK_RUN = 3'b001,
      BK_SYM = 3'b010,
      BK_END = 3'b100
   } bk_state_type;

endpackage

### sv/dfa_ram.sv
module dfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dfa_front.sv
module dfa_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dfa_pkg::MODE_W-1:0]    req_mode,
   input  logic [dfa_pkg::STATE_W-1:0]   req_state_id,
   input  logic [dfa_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic [dfa_pkg::STATE_W-1:0]   req_next_state,
   input  logic                          req_final_flag,
   input  logic                          clearing,
   input  logic                          q_full,
   output logic                          push,
   output dfa_pkg::cmd_type              push_cmd
);

   logic known;

   // Requests with an unused mode are accepted and dropped here.
   always_comb begin
      known               = 1'b1;
      push_cmd.op         = dfa_pkg::OP_LOAD;
      push_cmd.state_id   = req_state_id;
      push_cmd.symbol     = req_symbol;
      push_cmd.next_state = req_next_state;
      push_cmd.final_flag = req_final_flag;
      unique case (req_mode)
         dfa_pkg::MODE_LOAD:   push_cmd.op = dfa_pkg::OP_LOAD;
         dfa_pkg::MODE_FINAL:  push_cmd.op = dfa_pkg::OP_FINAL;
         dfa_pkg::MODE_START:  push_cmd.op = dfa_pkg::OP_START;
         dfa_pkg::MODE_SYMBOL: push_cmd.op = dfa_pkg::OP_SYMBOL;
         dfa_pkg::MODE_END:    push_cmd.op = dfa_pkg::OP_END;
         default:              known       = 1'b0;
      endcase
   end

   assign req_stall = q_full || clearing;
   assign push      = req_valid && !req_stall && known;

endmodule

### sv/dfa_cmd_queue.sv
module dfa_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfa_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output dfa_pkg::cmd_type head_cmd
);

   dfa_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full     = count_ff[1];
   assign valid    = count_ff != 2'd0;
   assign head_cmd = entry_ff[rd_ptr_ff];

endmodule

### sv/dfa_back.sv
module dfa_back #(
   parameter int STATE_BITS  = dfa_pkg::STATE_BITS_DEF,
   parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  dfa_pkg::cmd_type             q_cmd,
   output logic                         q_pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_accepted,
   output logic [dfa_pkg::STATE_W-1:0]  rsp_end_state,
   output logic                         rsp_stuck
);

   localparam int AW        = STATE_BITS + SYMBOL_BITS;
   localparam int TBL_DEPTH = 2 ** AW;
   localparam int FIN_DEPTH = 2 ** STATE_BITS;
   localparam int TBL_W     = STATE_BITS + 1;
   localparam int SW        = dfa_pkg::STATE_W;

   dfa_pkg::bk_state_type state_ff, state_in;
   logic [STATE_BITS-1:0] cur_ff, cur_in;
   logic                  dead_ff, dead_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff, rsp_accepted_in;
   logic [SW-1:0]         rsp_end_state_ff, rsp_end_state_in;
   logic                  rsp_stuck_ff, rsp_stuck_in;

   logic [STATE_BITS-1:0]  sid_m, nxt_m;
   logic [SYMBOL_BITS-1:0] sym_m;
   logic                   out_free;

   logic                   tbl_wr_en, tbl_rd_en;
   logic [AW-1:0]          tbl_wr_addr, tbl_rd_addr;
   logic [TBL_W-1:0]       tbl_wr_data, tbl_rd_data;
   logic                   fin_wr_en, fin_rd_en;
   logic [STATE_BITS-1:0]  fin_wr_addr, fin_rd_addr;
   logic                   fin_wr_data, fin_rd_data;

   assign sid_m    = STATE_BITS'(q_cmd.state_id);
   assign nxt_m    = STATE_BITS'(q_cmd.next_state);
   assign sym_m    = SYMBOL_BITS'(q_cmd.symbol);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      cur_in           = cur_ff;
      dead_in          = dead_ff;
      clr_busy_in      = clr_busy_ff;
      clr_addr_in      = clr_addr_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_accepted_in  = rsp_accepted_ff;
      rsp_end_state_in = rsp_end_state_ff;
      rsp_stuck_in     = rsp_stuck_ff;
      q_pop            = 1'b0;
      tbl_wr_en        = 1'b0;
      tbl_wr_addr      = {sid_m, sym_m};
      tbl_wr_data      = {1'b1, nxt_m};
      tbl_rd_en        = 1'b0;
      tbl_rd_addr      = {cur_ff, sym_m};
      fin_wr_en        = 1'b0;
      fin_wr_addr      = sid_m;
      fin_wr_data      = q_cmd.final_flag;
      fin_rd_en        = 1'b0;
      fin_rd_addr      = cur_ff;

      if (clr_busy_ff) begin
         // Sweep both tables to zero, one entry a cycle.
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = clr_addr_ff;
         tbl_wr_data = '0;
         fin_wr_en   = 1'b1;
         fin_wr_addr = clr_addr_ff[STATE_BITS-1:0];
         fin_wr_data = 1'b0;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {AW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            dfa_pkg::BK_RUN: begin
               if (q_valid) begin
                  q_pop = 1'b1;
                  case (q_cmd.op)
                     dfa_pkg::OP_LOAD: begin
                        tbl_wr_en = 1'b1;
                     end
                     dfa_pkg::OP_FINAL: begin
                        fin_wr_en = 1'b1;
                     end
                     dfa_pkg::OP_START: begin
                        cur_in  = sid_m;
                        dead_in = 1'b0;
                     end
                     dfa_pkg::OP_SYMBOL: begin
                        // A stuck string ignores further symbols.
                        if (!dead_ff) begin
                           tbl_rd_en = 1'b1;
                           state_in  = dfa_pkg::BK_SYM;
                        end
                     end
                     dfa_pkg::OP_END: begin
                        fin_rd_en = 1'b1;
                        state_in  = dfa_pkg::BK_END;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            dfa_pkg::BK_SYM: begin
               if (tbl_rd_data[TBL_W-1]) begin
                  cur_in = tbl_rd_data[STATE_BITS-1:0];
               end else begin
                  dead_in = 1'b1;
               end
               state_in = dfa_pkg::BK_RUN;
            end
            dfa_pkg::BK_END: begin
               // The read data holds while the response slot is occupied.
               if (out_free) begin
                  rsp_valid_in     = 1'b1;
                  rsp_accepted_in  = !dead_ff && fin_rd_data;
                  rsp_end_state_in = SW'(cur_ff);
                  rsp_stuck_in     = dead_ff;
                  state_in         = dfa_pkg::BK_RUN;
               end
            end
            default: begin
               state_in = dfa_pkg::BK_RUN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfa_pkg::BK_RUN;
         cur_ff       <= '0;
         dead_ff      <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         dead_ff      <= dead_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_accepted_ff  <= rsp_accepted_in;
      rsp_end_state_ff <= rsp_end_state_in;
      rsp_stuck_ff     <= rsp_stuck_in;
   end

   dfa_ram #(
      .WIDTH (TBL_W),
      .DEPTH (TBL_DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   dfa_ram #(
      .WIDTH (1),
      .DEPTH (FIN_DEPTH)
   ) u_final_ram (
      .clock   (clock),
      .wr_en   (fin_wr_en),
      .wr_addr (fin_wr_addr),
      .wr_data (fin_wr_data),
      .rd_en   (fin_rd_en),
      .rd_addr (fin_rd_addr),
      .rd_data (fin_rd_data)
   );

   assign clearing      = clr_busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_accepted_ff;
   assign rsp_end_state = rsp_end_state_ff;
   assign rsp_stuck     = rsp_stuck_ff;

endmodule

### sv/dfa_string_acceptor_top.sv
// Channel    Direction  Handshake           Payload
// request    in         req_valid/stall     mode, state_id, symbol, next_state, final_flag
// response   out        rsp_valid/stall     accepted, end_state, stuck
//
// Load, final-flag and start requests execute as they are popped; a symbol reads the
// registered transition memory and is applied in BK_SYM, unless the string is stuck.
// An end request reads the final-flag memory and waits in BK_END for the response slot.
// After reset a clearing pass of 2^(STATE_BITS+SYMBOL_BITS) entries (16384 by default)
// zeroes both tables while req_stall stays high. A two-entry queue decouples acceptance
// from execution; rsp_stall holds the response and stalls the back end only at an end.

module dfa_string_acceptor_top #(
   parameter int STATE_BITS  = dfa_pkg::STATE_BITS_DEF,
   parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dfa_pkg::MODE_W-1:0]    req_mode,
   input  logic [dfa_pkg::STATE_W-1:0]   req_state_id,
   input  logic [dfa_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic [dfa_pkg::STATE_W-1:0]   req_next_state,
   input  logic                          req_final_flag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [dfa_pkg::STATE_W-1:0]   rsp_end_state,
   output logic                          rsp_stuck
);

   // Front end to queue.
   logic             push;
   dfa_pkg::cmd_type push_cmd;
   logic             q_full;

   // Queue to back end.
   logic             q_valid;
   logic             q_pop;
   dfa_pkg::cmd_type q_cmd;

   // The back end holds the request side off while the tables are being cleared.
   logic             clearing;

   // The front end decodes the mode and drops requests with an unused code.
   dfa_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_state_id   (req_state_id),
      .req_symbol     (req_symbol),
      .req_next_state (req_next_state),
      .req_final_flag (req_final_flag),
      .clearing       (clearing),
      .q_full         (q_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   dfa_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (q_cmd)
   );

   // The back end owns the transition and final-flag memories, the current state and
   // the stuck mark, and the response register.
   dfa_back #(
      .STATE_BITS  (STATE_BITS),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_accepted  (rsp_accepted),
      .rsp_end_state (rsp_end_state),
      .rsp_stuck     (rsp_stuck)
   );

endmodule
